// ===== hdl/psdf_pkg.sv =====
// ----------------------------------------------------------------------------
// psdf_pkg: shared types and constants of the primitive distance evaluator
// Widths, shape codes, register indexes and the square-root cell payload.
// ----------------------------------------------------------------------------
package psdf_pkg;

   localparam int COORD_BITS = 24;
   localparam int EXT_BITS   = COORD_BITS - 1;
   // Magnitudes of differences need COORD_BITS+1 bits at most.
   localparam int MAG_BITS   = COORD_BITS + 1;
   // Sum of three squares.
   localparam int SUM_BITS   = 2 * MAG_BITS + 2;
   // Square root result bits.
   localparam int ROOT_BITS  = SUM_BITS / 2;
   // Bits of the index of one root bit.
   localparam int ROOT_IDX_BITS = $clog2(ROOT_BITS);
   localparam int DIST_BITS  = ROOT_BITS + 3;
   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic [1:0] {
      SHAPE_SPHERE  = 2'd0,
      SHAPE_BOX     = 2'd1,
      SHAPE_CAPSULE = 2'd2,
      SHAPE_UNKNOWN = 2'd3
   } shape_type;

   localparam logic [CSR_ADDR_BITS-1:0] REG_SHAPE_KIND = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CENTER_X   = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CENTER_Y   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CENTER_Z   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_EXTENT_X   = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_EXTENT_Y   = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] REG_EXTENT_Z   = 3'd6;

   // Beat travelling down the square-root chain.
   typedef struct packed {
      logic                        valid;
      logic [SUM_BITS-1:0]         rem;    // remaining radicand
      logic [ROOT_BITS-1:0]        root;   // partial root
      logic signed [DIST_BITS-1:0] offset; // added to the root at the end
      logic                        unknown;
   } sqrt_beat_type;

endpackage

// ===== hdl/psdf_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// psdf_sqrt_cell: one root bit of the restoring square root
// Tries the next root bit, keeps it if the trial fits, and registers the beat.
// ----------------------------------------------------------------------------
module psdf_sqrt_cell
   import psdf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ROOT_IDX_BITS-1:0] root_bit,
   input  sqrt_beat_type            beat_in,
   output sqrt_beat_type            beat_out
);

   sqrt_beat_type beat_ff, beat_in_w;
   logic [SUM_BITS:0] trial;
   logic [SUM_BITS:0] rem_ext;

   // trial = (2*root + 2^root_bit) * 2^root_bit, with root bits above root_bit
   always_comb begin
      trial = ({{(SUM_BITS+1-ROOT_BITS){1'b0}}, beat_in.root} << (root_bit + 1))
              + ({{SUM_BITS{1'b0}}, 1'b1} << (2 * root_bit));
      rem_ext = {1'b0, beat_in.rem};
      beat_in_w = beat_in;
      if (trial <= rem_ext) begin
         beat_in_w.rem = SUM_BITS'(rem_ext - trial);
         beat_in_w.root = beat_in.root | (ROOT_BITS'(1) << root_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in_w.valid;
      end
      beat_ff.rem     <= beat_in_w.rem;
      beat_ff.root    <= beat_in_w.root;
      beat_ff.offset  <= beat_in_w.offset;
      beat_ff.unknown <= beat_in_w.unknown;
   end

   assign beat_out = beat_ff;

endmodule

// ===== hdl/psdf_front.sv =====
// ----------------------------------------------------------------------------
// psdf_front: per-shape vector setup and sum of squares
// Two register stages: axis magnitudes and offset, then the squared sum.
// ----------------------------------------------------------------------------
module psdf_front
   import psdf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic signed [COORD_BITS-1:0] pz,
   input  shape_type                    kind,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic signed [COORD_BITS-1:0] cz,
   input  logic [EXT_BITS-1:0]          ex,
   input  logic [EXT_BITS-1:0]          ey,
   input  logic [EXT_BITS-1:0]          ez,
   output sqrt_beat_type                beat_out
);

   localparam int W = COORD_BITS + 2;

   logic signed [W-1:0] dx, dy, dz, qx, qy, qz, yr, m;
   logic [MAG_BITS-1:0] ax, ay, az;
   logic signed [DIST_BITS-1:0] off;

   logic [MAG_BITS-1:0] ax_ff, ay_ff, az_ff;
   logic signed [DIST_BITS-1:0] off_ff;
   logic unk_ff, v1_ff;
   sqrt_beat_type beat_ff;

   function automatic logic [MAG_BITS-1:0] mag(input logic signed [W-1:0] v);
      logic signed [W-1:0] a;
      a = (v < 0) ? -v : v;
      return MAG_BITS'(a);
   endfunction

   function automatic logic [MAG_BITS-1:0] pos(input logic signed [W-1:0] v);
      return (v > 0) ? MAG_BITS'(v) : '0;
   endfunction

   always_comb begin
      dx = W'(px) - W'(cx);
      dy = W'(py) - W'(cy);
      dz = W'(pz) - W'(cz);
      qx = W'(signed'({1'b0, mag(dx)})) - W'(signed'({1'b0, ex}));
      qy = W'(signed'({1'b0, mag(dy)})) - W'(signed'({1'b0, ey}));
      qz = W'(signed'({1'b0, mag(dz)})) - W'(signed'({1'b0, ez}));
      m = qx;
      if (qy > m) m = qy;
      if (qz > m) m = qz;
      if (W'(py) > W'(signed'({1'b0, ey}))) yr = W'(py) - W'(signed'({1'b0, ey}));
      else if (py >= 0) yr = '0;
      else yr = W'(py);
      case (kind)
         SHAPE_BOX: begin
            ax = pos(qx); ay = pos(qy); az = pos(qz);
            off = (m < 0) ? DIST_BITS'(m) : '0;
         end
         SHAPE_CAPSULE: begin
            ax = mag(W'(px)); ay = mag(yr); az = mag(W'(pz));
            off = -DIST_BITS'(signed'({1'b0, ex}));
         end
         default: begin
            ax = mag(dx); ay = mag(dy); az = mag(dz);
            off = -DIST_BITS'(signed'({1'b0, ex}));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         beat_ff.valid <= 1'b0;
      end else begin
         v1_ff <= start;
         beat_ff.valid <= v1_ff;
      end
      ax_ff <= ax; ay_ff <= ay; az_ff <= az;
      off_ff <= off;
      unk_ff <= (kind == SHAPE_UNKNOWN);
      beat_ff.rem <= SUM_BITS'(ax_ff * ax_ff) + SUM_BITS'(ay_ff * ay_ff)
                     + SUM_BITS'(az_ff * az_ff);
      beat_ff.root <= '0;
      beat_ff.offset <= off_ff;
      beat_ff.unknown <= unk_ff;
   end

   assign beat_out = beat_ff;

endmodule

// ===== hdl/primitive_sdf_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// primitive_sdf_evaluator_top: signed distance of a point to one primitive
// Sphere, box or vertical capsule, Q11.12 fixed point, saturating result.
// ----------------------------------------------------------------------------
// A point is taken on every cycle that start is high; busy never rises, so
// a new point may follow in every cycle. Each point gives one result beat on
// rsp_valid after it passes two setup stages (axis magnitudes, then the sum
// of squares), one cell per root bit in the square-root chain (ROOT_BITS
// cells) and one output register. The receiver cannot stall and none is
// needed. The shape registers must only be written while no point is in
// flight.
module primitive_sdf_evaluator_top
   import psdf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_point_z,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_distance,
   output logic                         rsp_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]     csr_index,
   input  logic [31:0]                  csr_data
);

   shape_type kind_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic [EXT_BITS-1:0] ex_ff, ey_ff, ez_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers; writes to unlisted indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= SHAPE_SPHERE;
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
         ex_ff <= EXT_BITS'(4096); ey_ff <= EXT_BITS'(4096); ez_ff <= EXT_BITS'(4096);
      end else if (csr_valid) begin
         case (csr_index)
            REG_SHAPE_KIND: kind_ff <= shape_type'(csr_data[1:0]);
            REG_CENTER_X:   cx_ff <= csr_data[COORD_BITS-1:0];
            REG_CENTER_Y:   cy_ff <= csr_data[COORD_BITS-1:0];
            REG_CENTER_Z:   cz_ff <= csr_data[COORD_BITS-1:0];
            REG_EXTENT_X:   ex_ff <= csr_data[EXT_BITS-1:0];
            REG_EXTENT_Y:   ey_ff <= csr_data[EXT_BITS-1:0];
            REG_EXTENT_Z:   ez_ff <= csr_data[EXT_BITS-1:0];
            default: ;
         endcase
      end
   end

   sqrt_beat_type chain [ROOT_BITS+1];

   psdf_front u_front (
      .clock(clock), .reset(reset), .start(start),
      .px(req_point_x), .py(req_point_y), .pz(req_point_z),
      .kind(kind_ff), .cx(cx_ff), .cy(cy_ff), .cz(cz_ff),
      .ex(ex_ff), .ey(ey_ff), .ez(ez_ff),
      .beat_out(chain[0])
   );

   // Root bits are resolved from the top bit down, one cell per bit.
   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
      psdf_sqrt_cell u_cell (
         .clock(clock), .reset(reset),
         .root_bit(ROOT_IDX_BITS'(ROOT_BITS - 1 - i)),
         .beat_in(chain[i]), .beat_out(chain[i+1])
      );
   end

   // Final add of the offset and saturation to the output range.
   localparam logic signed [DIST_BITS-1:0] MAXV = DIST_BITS'((1 << (COORD_BITS-1)) - 1);
   localparam logic signed [DIST_BITS-1:0] MINV = -MAXV - DIST_BITS'(1);

   sqrt_beat_type last;
   logic signed [DIST_BITS-1:0] d_sum;
   logic valid_ff, sat_ff;
   logic signed [COORD_BITS-1:0] dist_ff;

   assign last = chain[ROOT_BITS];
   assign d_sum = DIST_BITS'(signed'({1'b0, last.root})) + last.offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
      if (last.unknown || d_sum > MAXV) begin
         dist_ff <= MAXV[COORD_BITS-1:0];
         sat_ff <= 1'b1;
      end else if (d_sum < MINV) begin
         dist_ff <= MINV[COORD_BITS-1:0];
         sat_ff <= 1'b1;
      end else begin
         dist_ff <= d_sum[COORD_BITS-1:0];
         sat_ff <= 1'b0;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_saturated = sat_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      last.valid |=> rsp_valid) else $error("result beat lost");
   a_unknown: assert property (@(posedge clock) disable iff (reset)
      (last.valid && last.unknown) |=> rsp_saturated) else $error("unknown kind not flagged");
   a_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_saturated) |-> ($past(d_sum) <= MAXV && $past(d_sum) >= MINV))
      else $error("unsaturated result out of range");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the primitive signed-distance evaluator
// Sample points go in as bursts of start beats over configured shapes. Each
// result beat is compared with a table value or a distance computed in the bench.
// ----------------------------------------------------------------------------
module tb;
   import psdf_pkg::*;

   localparam int  LATENCY   = ROOT_BITS + 3;
   localparam int  IDLE_WAIT = LATENCY + 4;
   localparam int  WATCHDOG  = 4000;
   localparam int  PHASES    = 14;
   localparam int  PER_PHASE = 132;
   localparam logic signed [COORD_BITS-1:0] DMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] DMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [EXT_BITS-1:0]          EMAX = '1;
   localparam logic signed [COORD_BITS-1:0] ONE  = 4096;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [COORD_BITS-1:0] req_point_x = '0;
   logic signed [COORD_BITS-1:0] req_point_y = '0;
   logic signed [COORD_BITS-1:0] req_point_z = '0;
   logic                         rsp_valid;
   logic signed [COORD_BITS-1:0] rsp_distance;
   logic                         rsp_saturated;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_ADDR_BITS-1:0]     csr_index = '0;
   logic [31:0]                  csr_data  = '0;

   // A distance together with its saturation flag, as the block reports it.
   typedef struct {
      logic signed [COORD_BITS-1:0] distance;
      logic                         sat;
   } dist_result_type;

   // One row of the directed table. Rows with has_value carry a result that
   // is obvious by inspection; the others are checked against the predictor.
   typedef struct {
      shape_type                    kind;
      logic signed [COORD_BITS-1:0] x, y, z;
      bit                           has_value;
      logic signed [COORD_BITS-1:0] distance;
      logic                         sat;
   } probe_row_type;

   // Shadow copy of the shape registers, updated on every accepted write.
   // The initial values are the reset state of the block.
   shape_type                    kind_q = SHAPE_SPHERE;
   logic signed [COORD_BITS-1:0] cen_x = '0;
   logic signed [COORD_BITS-1:0] cen_y = '0;
   logic signed [COORD_BITS-1:0] cen_z = '0;
   logic [EXT_BITS-1:0]          ext_x = EXT_BITS'(4096);
   logic [EXT_BITS-1:0]          ext_y = EXT_BITS'(4096);
   logic [EXT_BITS-1:0]          ext_z = EXT_BITS'(4096);

   dist_result_type pending_dist[$];
   int              mismatches = 0;
   int              quiet_cycles = 0;
   int              burst_left;

   always #5 clock = ~clock;

   primitive_sdf_evaluator_top i_dut (.*);

   // Exact floor square root, one root bit per pass, as the hardware chain.
   function automatic longint isqrt(input longint n);
      longint r;
      longint cand;
      r = 0;
      for (int b = 27; b >= 0; b--) begin
         cand = r | (longint'(1) << b);
         if (cand * cand <= n)
            r = cand;
      end
      return r;
   endfunction

   function automatic longint len3(input longint a, input longint b, input longint c);
      return isqrt(a * a + b * b + c * c);
   endfunction

   function automatic longint absl(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Signed distance of one point to the shape held in the shadow registers.
   function automatic dist_result_type shape_distance(
         input logic signed [COORD_BITS-1:0] px,
         input logic signed [COORD_BITS-1:0] py,
         input logic signed [COORD_BITS-1:0] pz);
      dist_result_type res;
      longint          d, qx, qy, qz, m, yr;
      res.sat = 1'b0;
      d = 0;
      case (kind_q)
         SHAPE_SPHERE: begin
            d = len3(absl(px - cen_x), absl(py - cen_y), absl(pz - cen_z)) - ext_x;
         end
         SHAPE_BOX: begin
            qx = absl(px - cen_x) - ext_x;
            qy = absl(py - cen_y) - ext_y;
            qz = absl(pz - cen_z) - ext_z;
            m = qx;
            if (qy > m) m = qy;
            if (qz > m) m = qz;
            d = len3(qx > 0 ? qx : 0, qy > 0 ? qy : 0, qz > 0 ? qz : 0) + (m < 0 ? m : 0);
         end
         SHAPE_CAPSULE: begin
            // The capsule ignores the center; its axis runs from 0 up to ext_y.
            yr = py;
            if (longint'(py) > longint'(ext_y))
               yr = py - longint'(ext_y);
            else if (py >= 0)
               yr = 0;
            d = len3(absl(px), absl(yr), absl(pz)) - ext_x;
         end
         default: begin
            d = DMAX;
            res.sat = 1'b1;
         end
      endcase
      if (d > longint'(DMAX)) begin
         d = DMAX;
         res.sat = 1'b1;
      end
      if (d < longint'(DMIN)) begin
         d = DMIN;
         res.sat = 1'b1;
      end
      res.distance = d[COORD_BITS-1:0];
      return res;
   endfunction

   // Register writes land in the shadow copy at the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            REG_SHAPE_KIND: kind_q <= shape_type'(csr_data[1:0]);
            REG_CENTER_X:   cen_x  <= csr_data[COORD_BITS-1:0];
            REG_CENTER_Y:   cen_y  <= csr_data[COORD_BITS-1:0];
            REG_CENTER_Z:   cen_z  <= csr_data[COORD_BITS-1:0];
            REG_EXTENT_X:   ext_x  <= csr_data[EXT_BITS-1:0];
            REG_EXTENT_Y:   ext_y  <= csr_data[EXT_BITS-1:0];
            REG_EXTENT_Z:   ext_z  <= csr_data[EXT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Result checker: every result beat must match the oldest expectation.
   always @(posedge clock) begin
      dist_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_dist.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat, distance %0d sat %0b",
                        $realtime, rsp_distance, rsp_saturated);
         end else begin
            want = pending_dist.pop_front();
            if (rsp_distance !== want.distance || rsp_saturated !== want.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: distance %0d sat %0b, expected %0d sat %0b",
                           $realtime, rsp_distance, rsp_saturated, want.distance,
                           want.sat);
            end
         end
      end
   end

   // Watchdog: any accepted beat resets the count of quiet cycles.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Lower start, let every outstanding result drain, and then give the
   // pipeline its full depth before touching the registers.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pending_dist.size() != 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Sends one point beat. The sender works in bursts: between bursts start
   // may drop, and no burst, short or long, has any gaps within it.
   // The expectation is queued at the accepting edge, from the table when the
   // row has a fixed value and from the predictor otherwise.
   task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                             input logic signed [COORD_BITS-1:0] y,
                             input logic signed [COORD_BITS-1:0] z,
                             input bit has_value, input dist_result_type fixed);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start       <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do
         @(posedge clock);
      while (busy);
      pending_dist.push_back(has_value ? fixed : shape_distance(x, y, z));
   endtask

   function automatic logic [31:0] rand_word_low(input logic [31:0] low, input int bits);
      logic [31:0] w;
      w = $urandom;
      // Upper bits beyond the register are noise that the block must drop.
      for (int i = 0; i < bits; i++)
         w[i] = low[i];
      return w;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_center();
      case ($urandom_range(0, 5))
         0: return DMAX;
         1: return DMIN;
         2: return '0;
         3: return COORD_BITS'($urandom_range(0, 65535) - 32768);
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [EXT_BITS-1:0] pick_extent();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return EMAX;
         2: return EXT_BITS'($urandom_range(0, 40000));
         default: return EXT_BITS'($urandom);
      endcase
   endfunction

   // Point near the configured surface, or anywhere in the field now and then.
   function automatic logic signed [COORD_BITS-1:0] pick_coord(
         input logic signed [COORD_BITS-1:0] c,
         input logic [EXT_BITS-1:0] e);
      longint v;
      case ($urandom_range(0, 9))
         0: return DMAX;
         1: return DMIN;
         2, 3: return COORD_BITS'($urandom);
         default: begin
            v = longint'(c) + longint'($urandom_range(0, 2 * e + 8192)) - longint'(e) - 4096;
            if (v > longint'(DMAX)) v = DMAX;
            if (v < longint'(DMIN)) v = DMIN;
            return v[COORD_BITS-1:0];
         end
      endcase
   endfunction

   probe_row_type probes[] = '{
      // Reset state: unit sphere at the origin.
      '{SHAPE_SPHERE,  0,      0,      0,    1, -ONE, 1'b0},
      '{SHAPE_SPHERE,  ONE,    0,      0,    1, 0,    1'b0},
      '{SHAPE_SPHERE,  DMIN,   DMIN,   DMIN, 1, DMAX, 1'b1},
      '{SHAPE_SPHERE,  DMAX,   DMAX,   DMAX, 1, DMAX, 1'b1},
      '{SHAPE_SPHERE,  0,      -ONE,   7,    0, 0,    1'b0},
      '{SHAPE_SPHERE,  DMAX,   0,      0,    0, 0,    1'b0},
      // Unit box.
      '{SHAPE_BOX,     0,      0,      0,    1, -ONE, 1'b0},
      '{SHAPE_BOX,     2*ONE,  0,      0,    1, ONE,  1'b0},
      '{SHAPE_BOX,     2*ONE,  2*ONE,  0,    0, 0,    1'b0},
      '{SHAPE_BOX,     DMIN,   0,      0,    0, 0,    1'b0},
      '{SHAPE_BOX,     DMAX,   DMAX,   DMAX, 1, DMAX, 1'b1},
      // Capsule: inside the shaft, on the caps, beyond both ends.
      '{SHAPE_CAPSULE, 0,      0,      0,    1, -ONE, 1'b0},
      '{SHAPE_CAPSULE, 0,      ONE/2,  0,    1, -ONE, 1'b0},
      '{SHAPE_CAPSULE, 0,      2*ONE,  0,    1, 0,    1'b0},
      '{SHAPE_CAPSULE, 0,      -ONE,   0,    1, 0,    1'b0},
      '{SHAPE_CAPSULE, 0,      DMIN,   0,    0, 0,    1'b0},
      '{SHAPE_CAPSULE, DMAX,   DMAX,   DMIN, 0, 0,    1'b0},
      // Unrecognized kind always reports the largest distance.
      '{SHAPE_UNKNOWN, 0,      0,      0,    1, DMAX, 1'b1},
      '{SHAPE_UNKNOWN, DMIN,   DMAX,   DMIN, 1, DMAX, 1'b1}
   };

   initial begin
      dist_result_type fixed;
      shape_type       cur_kind;
      burst_left   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the kind register changes only between groups of rows.
      cur_kind = SHAPE_SPHERE;
      foreach (probes[i]) begin
         if (probes[i].kind != cur_kind) begin
            drain_pipeline();
            write_reg(REG_SHAPE_KIND, {30'd0, probes[i].kind});
            cur_kind = probes[i].kind;
         end
         fixed.distance = probes[i].distance;
         fixed.sat      = probes[i].sat;
         send_point(probes[i].x, probes[i].y, probes[i].z, probes[i].has_value, fixed);
      end

      // Random part: a fresh shape per phase, then points around it.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_pipeline();
         write_reg(REG_SHAPE_KIND, rand_word_low(ph % 4, 2));
         write_reg(REG_CENTER_X, rand_word_low(pick_center(), COORD_BITS));
         write_reg(REG_CENTER_Y, rand_word_low(pick_center(), COORD_BITS));
         write_reg(REG_CENTER_Z, rand_word_low(pick_center(), COORD_BITS));
         write_reg(REG_EXTENT_X, rand_word_low(pick_extent(), EXT_BITS));
         write_reg(REG_EXTENT_Y, rand_word_low(pick_extent(), EXT_BITS));
         write_reg(REG_EXTENT_Z, rand_word_low(pick_extent(), EXT_BITS));
         // An index past the register list must be ignored.
         if (ph % 5 == 0)
            write_reg(3'd7, $urandom);
         for (int n = 0; n < PER_PHASE; n++) begin
            // The capsule sits at the origin whatever the center registers say.
            if (kind_q == SHAPE_CAPSULE)
               send_point(pick_coord(0, ext_x), pick_coord(ext_y / 2, ext_y), pick_coord(0, ext_x),
                          0, fixed);
            else
               send_point(pick_coord(cen_x, ext_x), pick_coord(cen_y, ext_y),
                          pick_coord(cen_z, ext_z), 0, fixed);
         end
      end

      drain_pipeline();
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
